/* rtl/bqc_pkg.sv */
`default_nettype none
package bqc_pkg;

    localparam int DEF_MAX_ORDER   = 32;
    localparam int DEF_QUEUE_DEPTH = 2;
    localparam int RESET_ORDER     = 32;

    localparam int ORDER_W  = 6;
    localparam int SAMPLE_W = 24;
    localparam int COEFF_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int SELECT_W = 2;
    localparam int DELAY_W  = 40;

    localparam logic OP_COEFF = 1'b1;

    localparam logic [SELECT_W-1:0] SEL_GAIN = 2'd0;
    localparam logic [SELECT_W-1:0] SEL_A1   = 2'd1;
    localparam logic [SELECT_W-1:0] SEL_A2   = 2'd2;

    // decoded word handed from front to back
    typedef struct packed {
        logic                       is_coeff;
        logic                       we_gain;
        logic                       we_a1;
        logic                       we_a2;
        logic [INDEX_W-1:0]         section;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [COEFF_W-1:0]  coeff;
    } cmd_t;

endpackage
`default_nettype wire

/* rtl/bqc_front.sv */
`default_nettype none
module bqc_front #(
    parameter int MAX_ORDER = bqc_pkg::DEF_MAX_ORDER
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [bqc_pkg::INDEX_W-1:0]         section_index,
    input  logic [bqc_pkg::SELECT_W-1:0]        coeff_select,
    input  logic signed [bqc_pkg::COEFF_W-1:0]  coeff_value,
    input  logic                                q_ready,
    output logic                                q_push,
    output bqc_pkg::cmd_t                       q_data
);

    localparam int NSEC = MAX_ORDER / 2;

    logic          hold_valid_reg;
    logic          hold_valid_next;
    bqc_pkg::cmd_t hold_reg;
    bqc_pkg::cmd_t hold_next;
    logic          accept;
    logic          idx_ok;

    assign in_stall = hold_valid_reg && !q_ready;
    assign accept   = in_valid && !in_stall;
    assign q_push   = hold_valid_reg && q_ready;
    assign q_data   = hold_reg;

    assign idx_ok = (32'(section_index) < 32'(NSEC));

    always_comb
    begin
        hold_next          = '0;
        hold_next.is_coeff = (operation == bqc_pkg::OP_COEFF);
        hold_next.section  = section_index;
        hold_next.sample   = sample_in;
        hold_next.coeff    = coeff_value;
        case (coeff_select)
            bqc_pkg::SEL_GAIN: hold_next.we_gain = hold_next.is_coeff && idx_ok;
            bqc_pkg::SEL_A1:   hold_next.we_a1   = hold_next.is_coeff && idx_ok;
            bqc_pkg::SEL_A2:   hold_next.we_a2   = hold_next.is_coeff && idx_ok;
            default:           hold_next.we_gain = 1'b0;
        endcase
    end

    assign hold_valid_next = accept || (hold_valid_reg && !q_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= hold_next;
        end
    end

`ifndef SYNTHESIS
    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !q_ready) |=> (hold_valid_reg && $stable(hold_reg)))
        else $error("front word lost while queue full");
`endif

endmodule
`default_nettype wire

/* rtl/bqc_queue.sv */
`default_nettype none
module bqc_queue #(
    parameter int DEPTH = bqc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bqc_pkg::cmd_t push_data,
    output logic          ready,
    output logic          valid,
    output bqc_pkg::cmd_t pop_data,
    input  logic          pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bqc_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign ready    = (count_reg != CNT_FULL);
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue push not counted");
`endif

endmodule
`default_nettype wire

/* rtl/bqc_back.sv */
`default_nettype none
module bqc_back #(
    parameter int MAX_ORDER = bqc_pkg::DEF_MAX_ORDER
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  bqc_pkg::cmd_t                       q_data,
    output logic                                q_pop,
    input  logic                                cfg_we,
    input  logic [bqc_pkg::ORDER_W-1:0]         cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bqc_pkg::SAMPLE_W-1:0] sample_out
);

    localparam int NSEC    = MAX_ORDER / 2;
    localparam int SEC_W   = (NSEC > 1) ? $clog2(NSEC) : 1;
    localparam int ORDER_W = bqc_pkg::ORDER_W;
    localparam int DW      = bqc_pkg::DELAY_W;
    localparam int CW      = bqc_pkg::COEFF_W;
    localparam int SW      = bqc_pkg::SAMPLE_W;
    localparam int LO_W    = 16;
    localparam int MB_W    = DW - LO_W + 1;
    localparam int MUL_W   = CW + MB_W;
    localparam int P_W     = MUL_W + LO_W + 1;
    localparam int ACC_W   = P_W - 30;

    localparam logic [ORDER_W-1:0] ORDER_RST =
        ORDER_W'((MAX_ORDER < bqc_pkg::RESET_ORDER) ? MAX_ORDER : bqc_pkg::RESET_ORDER);

    localparam logic signed [P_W-1:0]   RND_Q30 = P_W'(64'sd1 <<< 29);
    localparam logic signed [DW:0]      RND_OUT = (DW + 1)'(128);
    localparam logic signed [ACC_W-1:0] POS40   = {{(ACC_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] NEG40   = ~POS40;
    localparam logic signed [DW:0]      POS24   = (DW + 1)'(8388607);
    localparam logic signed [DW:0]      NEG24   = ~POS24;

    // per-section step plan on the shared multiplier
    localparam logic [3:0] STEP_MUL_LAST  = 4'd5;
    localparam logic [3:0] STEP_RND_FIRST = 4'd2;
    localparam logic [3:0] STEP_RND_LAST  = 4'd6;
    localparam logic [3:0] STEP_ACC0      = 4'd3;
    localparam logic [3:0] STEP_ACC1      = 4'd5;
    localparam logic [3:0] STEP_ACC2      = 4'd7;
    localparam logic [3:0] STEP_WSAT      = 4'd8;
    localparam logic [3:0] STEP_LAST      = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    function automatic logic signed [DW-1:0] sat40(input logic signed [ACC_W-1:0] x);
        logic signed [DW-1:0] r;
        if (x > POS40)
            r = POS40[DW-1:0];
        else if (x < NEG40)
            r = NEG40[DW-1:0];
        else
            r = x[DW-1:0];
        return r;
    endfunction

    function automatic logic signed [SW-1:0] sat24(input logic signed [DW:0] x);
        logic signed [SW-1:0] r;
        if (x > POS24)
            r = POS24[SW-1:0];
        else if (x < NEG24)
            r = NEG24[SW-1:0];
        else
            r = x[SW-1:0];
        return r;
    endfunction

    state_t                    state_reg;
    state_t                    state_next;
    logic [3:0]                step_reg;
    logic [3:0]                step_next;
    logic [SEC_W-1:0]          sec_reg;
    logic [SEC_W-1:0]          sec_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [ORDER_W-1:0]        order_reg;
    logic [ORDER_W-1:0]        order_next;

    logic signed [CW-1:0]      gain_reg [NSEC];
    logic signed [CW-1:0]      fb1_reg  [NSEC];
    logic signed [CW-1:0]      fb2_reg  [NSEC];
    logic signed [DW-1:0]      d1_reg   [NSEC];
    logic signed [DW-1:0]      d2_reg   [NSEC];

    logic signed [MUL_W-1:0]   mul_reg;
    logic signed [MUL_W-1:0]   mul_next;
    logic signed [MUL_W-1:0]   lo_reg;
    logic signed [ACC_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DW-1:0]      w_reg;
    logic signed [DW-1:0]      y_reg;
    logic signed [SW-1:0]      sample_out_reg;
    logic signed [SW-1:0]      sample_out_next;

    logic [ORDER_W-2:0]        nsec;
    logic                      last_sec;
    logic                      out_free;
    logic                      run;
    logic                      clear;
    logic                      delay_we;
    logic                      lo_cap;
    logic                      rnd_en;
    logic [SEC_W-1:0]          wr_sec;
    logic signed [CW-1:0]      coef_sel;
    logic signed [DW-1:0]      data_sel;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [P_W-1:0]     p_full;
    logic signed [ACC_W-1:0]   y_sum;
    logic signed [DW:0]        y_rnd;
    logic signed [DW:0]        y_shift;

    assign nsec       = order_reg[ORDER_W-1:1];
    assign last_sec   = ((ORDER_W'(sec_reg) + 1'b1) == ORDER_W'(nsec));
    assign out_free   = !out_valid_reg || !out_stall;
    assign run        = (state_reg == ST_RUN);
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign clear      = cfg_we || (q_pop && q_data.is_coeff);
    assign delay_we   = run && (step_reg == STEP_LAST);
    assign lo_cap     = run && step_reg[0] && (step_reg <= STEP_MUL_LAST);
    assign rnd_en     = run && !step_reg[0] && (step_reg >= STEP_RND_FIRST)
                        && (step_reg <= STEP_RND_LAST);
    assign wr_sec     = SEC_W'(q_data.section);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    always_comb
    begin
        case (step_reg[2:1])
            2'd0:
            begin
                coef_sel = gain_reg[sec_reg];
                data_sel = y_reg;
            end
            2'd1:
            begin
                coef_sel = fb1_reg[sec_reg];
                data_sel = d1_reg[sec_reg];
            end
            default:
            begin
                coef_sel = fb2_reg[sec_reg];
                data_sel = d2_reg[sec_reg];
            end
        endcase
    end

    // low half unsigned, high half signed
    assign mul_b = step_reg[0] ? {data_sel[DW-1], data_sel[DW-1:LO_W]}
                               : {{(MB_W - LO_W){1'b0}}, data_sel[LO_W-1:0]};
    assign mul_next = MUL_W'(coef_sel) * MUL_W'(mul_b);

    assign p_full    = (P_W'(mul_reg) <<< LO_W) + P_W'(lo_reg) + RND_Q30;
    assign prod_next = p_full[P_W-1:30];

    assign y_sum = ACC_W'(w_reg) + (ACC_W'(d1_reg[sec_reg]) <<< 1) + ACC_W'(d2_reg[sec_reg]);

    assign y_rnd           = (DW + 1)'(y_reg) + RND_OUT;
    assign y_shift         = y_rnd >>> 8;
    assign sample_out_next = sat24(y_shift);

    always_comb
    begin
        order_next = order_reg;
        if (cfg_we)
        begin
            order_next = ({1'b0, cfg_data} > (ORDER_W + 1)'(MAX_ORDER))
                         ? ORDER_W'(MAX_ORDER) : cfg_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sec_next       = sec_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && !q_data.is_coeff)
                begin
                    step_next  = '0;
                    sec_next   = '0;
                    state_next = (nsec == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg == STEP_LAST)
                begin
                    step_next = '0;
                    if (last_sec)
                        state_next = ST_DONE;
                    else
                        sec_next = sec_reg + 1'b1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
            order_reg     <= ORDER_RST;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
            order_reg     <= order_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSEC; i++)
            begin
                d1_reg[i] <= '0;
                d2_reg[i] <= '0;
            end
        end
        else if (clear)
        begin
            for (int i = 0; i < NSEC; i++)
            begin
                d1_reg[i] <= '0;
                d2_reg[i] <= '0;
            end
        end
        else if (delay_we)
        begin
            d1_reg[sec_reg] <= w_reg;
            d2_reg[sec_reg] <= d1_reg[sec_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_next;
        if (lo_cap)
            lo_reg <= mul_reg;
        if (rnd_en)
            prod_reg <= prod_next;
        if (run && (step_reg == STEP_ACC0))
            acc_reg <= prod_reg;
        else if (run && ((step_reg == STEP_ACC1) || (step_reg == STEP_ACC2)))
            acc_reg <= acc_reg - prod_reg;
        if (run && (step_reg == STEP_WSAT))
            w_reg <= sat40(acc_reg);
        if (q_pop && !q_data.is_coeff)
            y_reg <= DW'(q_data.sample) <<< 8;
        else if (delay_we)
            y_reg <= sat40(y_sum);
        if (q_pop && q_data.we_gain)
            gain_reg[wr_sec] <= q_data.coeff;
        if (q_pop && q_data.we_a1)
            fb1_reg[wr_sec] <= q_data.coeff;
        if (q_pop && q_data.we_a2)
            fb2_reg[wr_sec] <= q_data.coeff;
        if ((state_reg == ST_DONE) && out_free)
            sample_out_reg <= sample_out_next;
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        run |-> (step_reg <= STEP_LAST))
        else $error("section step out of range");

    a_sec_active: assert property (@(posedge clk) disable iff (!rst_n)
        run |-> (ORDER_W'(sec_reg) < ORDER_W'(nsec)))
        else $error("inactive section processed");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_free) |=> out_valid_reg)
        else $error("finished sample not presented");
`endif

endmodule
`default_nettype wire

/* rtl/biquad_cascade_lowpass.sv */
// Lowpass biquad cascade, filter_order/2 direct form II sections.
// Input channel: in_valid / in_stall with operation, sample_in, section_index,
//   coeff_select, coeff_value. A word is taken when in_valid is high and
//   in_stall low. Operation filter gives one sample_out word; operation
//   coefficient loads K, a1 or a2 of one section (select 3 loads none),
//   gives no word and clears all delays.
// Output channel: out_valid / out_stall with sample_out. While the receiver
//   stalls the word holds; the back end goes on with the next input word and
//   waits only when a second result is ready.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_data is the order,
//   clamped to MAX_ORDER; every write clears the delays. Write only when idle.
// Datapath: one shared 32x25 multiplier, two passes per product, three
//   products per section. The back end takes no new word until it has
//   finished the current sample.
// Path: each input word passes the input register and the command queue
//   before the back end takes it.
// Reset: order is 32 (or MAX_ORDER if smaller), delays zero, queue empty;
//   coefficients are undefined until written.
`default_nettype none
module biquad_cascade_lowpass #(
    parameter int MAX_ORDER   = bqc_pkg::DEF_MAX_ORDER,
    parameter int QUEUE_DEPTH = bqc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [bqc_pkg::INDEX_W-1:0]         section_index,
    input  logic [bqc_pkg::SELECT_W-1:0]        coeff_select,
    input  logic signed [bqc_pkg::COEFF_W-1:0]  coeff_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bqc_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bqc_pkg::ORDER_W-1:0]         cfg_data
);

    logic          push;
    logic          push_ready;
    bqc_pkg::cmd_t push_data;
    logic          pop;
    logic          pop_valid;
    bqc_pkg::cmd_t pop_data;
    logic          cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    bqc_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .sample_in     (sample_in),
        .section_index (section_index),
        .coeff_select  (coeff_select),
        .coeff_value   (coeff_value),
        .q_ready       (push_ready),
        .q_push        (push),
        .q_data        (push_data)
    );

    bqc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .ready     (push_ready),
        .valid     (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop)
    );

    bqc_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (pop_valid),
        .q_data     (pop_data),
        .q_pop      (pop),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule
`default_nettype wire

/* tb/sv/biquad_cascade_lowpass_checker.sv */
module biquad_cascade_lowpass_checker #(
    parameter int MAX_ORDER = bqc_pkg::DEF_MAX_ORDER
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                operation,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [bqc_pkg::INDEX_W-1:0]         section_index,
    input  logic [bqc_pkg::SELECT_W-1:0]        coeff_select,
    input  logic signed [bqc_pkg::COEFF_W-1:0]  coeff_value,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [bqc_pkg::ORDER_W-1:0]         cfg_data,
    output int                                  mismatches,
    output int                                  samples_due
);
    import bqc_pkg::*;

    localparam int     SECTIONS   = MAX_ORDER / 2;
    localparam longint DELAY_MAX  = (longint'(1) <<< (DELAY_W - 1)) - 1;
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;

    logic signed [COEFF_W-1:0]  gain_k   [SECTIONS];
    logic signed [COEFF_W-1:0]  fb_a1    [SECTIONS];
    logic signed [COEFF_W-1:0]  fb_a2    [SECTIONS];
    longint                     w_last   [SECTIONS];
    longint                     w_prev   [SECTIONS];
    int unsigned                order_now;
    logic signed [SAMPLE_W-1:0] expected_samples [$];

    function automatic longint clamp(input longint v, input longint hi);
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Q2.30 times Q9.31, rounded half up back to Q9.31
    function automatic longint scale_q30(input logic signed [COEFF_W-1:0] c, input longint d);
        logic signed [79:0] prod;
        prod = c;
        prod = prod * d;
        prod = prod + (80'sd1 <<< 29);
        prod = prod >>> 30;
        return longint'(prod);
    endfunction

    function automatic void clear_delays();
        foreach (w_last[i])
        begin
            w_last[i] = 0;
            w_prev[i] = 0;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] cascade_output(
        input logic signed [SAMPLE_W-1:0] x
    );
        longint acc;
        longint w;
        longint d1;
        longint d2;
        acc = longint'(x) * 256;
        for (int i = 0; i < SECTIONS && i < int'(order_now / 2); i++)
        begin
            d1 = w_last[i];
            d2 = w_prev[i];
            w = scale_q30(gain_k[i], acc) - scale_q30(fb_a1[i], d1)
                - scale_q30(fb_a2[i], d2);
            w = clamp(w, DELAY_MAX);
            acc = clamp(w + 2 * d1 + d2, DELAY_MAX);
            w_prev[i] = d1;
            w_last[i] = w;
        end
        acc = clamp((acc + 128) >>> 8, SAMPLE_MAX);
        return acc[SAMPLE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_now = (RESET_ORDER > MAX_ORDER) ? MAX_ORDER : RESET_ORDER;
            foreach (gain_k[i])
            begin
                gain_k[i] = '0;
                fb_a1[i]  = '0;
                fb_a2[i]  = '0;
            end
            clear_delays();
            expected_samples.delete();
            mismatches  = 0;
            samples_due = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                order_now = (cfg_data > MAX_ORDER) ? MAX_ORDER : cfg_data;
                clear_delays();
            end

            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("sample_out word with none expected: actual %0d", sample_out);
                    mismatches++;
                end
                else if (sample_out !== expected_samples[0])
                begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           expected_samples[0], sample_out);
                    mismatches++;
                    void'(expected_samples.pop_front());
                end
                else
                    void'(expected_samples.pop_front());
            end

            if (in_valid && !in_stall)
            begin
                if (operation == OP_COEFF)
                begin
                    if (section_index < SECTIONS)
                    begin
                        if (coeff_select == SEL_GAIN)
                            gain_k[section_index] = coeff_value;
                        else if (coeff_select == SEL_A1)
                            fb_a1[section_index] = coeff_value;
                        else if (coeff_select == SEL_A2)
                            fb_a2[section_index] = coeff_value;
                    end
                    clear_delays();
                end
                else
                    expected_samples.push_back(cascade_output(sample_in));
            end

            samples_due = expected_samples.size();
        end
    end

endmodule

/* tb/sv/biquad_cascade_lowpass_tb.sv */
module biquad_cascade_lowpass_tb;
    import bqc_pkg::*;

    localparam int SECTIONS      = DEF_MAX_ORDER / 2;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 600;
    localparam int IDLE_LIMIT    = 5000;

    localparam logic                OP_FILTER = 1'b0;
    localparam logic [SELECT_W-1:0] SEL_NONE  = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [INDEX_W-1:0]         section_index;
    logic [SELECT_W-1:0]        coeff_select;
    logic signed [COEFF_W-1:0]  coeff_value;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [ORDER_W-1:0]         cfg_data;

    int mismatches;
    int samples_due;
    int hold_requests;
    int burst_left;
    int active_sections;

    biquad_cascade_lowpass u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .sample_in     (sample_in),
        .section_index (section_index),
        .coeff_select  (coeff_select),
        .coeff_value   (coeff_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    biquad_cascade_lowpass_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .sample_in     (sample_in),
        .section_index (section_index),
        .coeff_select  (coeff_select),
        .coeff_value   (coeff_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .samples_due   (samples_due)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push_word(input logic op, input logic signed [SAMPLE_W-1:0] s,
                             input logic [INDEX_W-1:0] sec, input logic [SELECT_W-1:0] sel,
                             input logic signed [COEFF_W-1:0] val);
        operation     = op;
        sample_in     = s;
        section_index = sec;
        coeff_select  = sel;
        coeff_value   = val;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic filter_sample(input logic signed [SAMPLE_W-1:0] s);
        push_word(OP_FILTER, s, INDEX_W'($urandom), SELECT_W'($urandom), $urandom);
    endtask

    task automatic write_coeff(input int sec, input logic [SELECT_W-1:0] sel,
                               input logic signed [COEFF_W-1:0] val);
        push_word(OP_COEFF, SAMPLE_W'($urandom), INDEX_W'(sec), sel, val);
    endtask

    // poles inside the stability triangle, unity gain at DC
    task automatic load_stable_section(input int sec);
        longint one;
        longint a1;
        longint a2;
        longint lim;
        one = longint'(1) <<< 30;
        a2  = longint'($urandom_range(0, 1850)) - 900;
        lim = (1000 + a2) * 95 / 100;
        a1  = longint'($urandom_range(0, 2 * lim)) - lim;
        a1  = a1 * one / 1000;
        a2  = a2 * one / 1000;
        write_coeff(sec, SEL_GAIN, COEFF_W'((one + a1 + a2) / 4));
        write_coeff(sec, SEL_A1, COEFF_W'(a1));
        write_coeff(sec, SEL_A2, COEFF_W'(a2));
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        logic signed [SAMPLE_W-1:0] s;
        s = SAMPLE_W'($urandom);
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 4))
                    0: s = SAMPLE_MAX;
                    1: s = SAMPLE_MIN;
                    2: s = '0;
                    3: s = 1;
                    default: s = -1;
                endcase
            1, 2:
                s = s >>> $urandom_range(6, 20);
            default: ;
        endcase
        return s;
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // coefficient writes give no word, so allow the back end to finish them
    task automatic drain();
        in_valid = 1'b0;
        while (samples_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_order(input logic [ORDER_W-1:0] v);
        drain();
        cfg_data  = v;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        active_sections = ((v > DEF_MAX_ORDER) ? DEF_MAX_ORDER : v) / 2;
    endtask

    task automatic run_phase(input int words, input logic [ORDER_W-1:0] order, input bit hold);
        int roll;
        set_order(order);
        for (int i = 0; i < active_sections; i++)
            load_stable_section(i);
        if (hold)
            hold_requests++;
        burst_left = 0;
        for (int n = 0; n < words; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 88)
                filter_sample(draw_sample());
            else if (roll < 94)
                load_stable_section($urandom_range(0, SECTIONS - 1));
            else if (roll < 97)
                write_coeff($urandom_range(0, SECTIONS - 1), SELECT_W'($urandom_range(0, 3)),
                            $urandom);
            else
                write_coeff($urandom_range(0, SECTIONS - 1), SEL_NONE, $urandom);
            pace_sender();
        end
    endtask

    // receiver
    initial
    begin
        stall_mode_e stall_mode;
        int          stall_left;
        int          holds_served;
        out_stall    = 1'b0;
        stall_mode   = STALL_NONE;
        stall_left   = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                @(negedge clk);
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = stall_mode_e'($urandom_range(0, 3));
                    stall_left = $urandom_range(20, 200);
                end
                stall_left--;
                @(negedge clk);
                case (stall_mode)
                    STALL_NONE:  out_stall = 1'b0;
                    STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
                    default:     out_stall = ~out_stall;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL biquad_cascade_lowpass");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        operation       = OP_FILTER;
        sample_in       = '0;
        section_index   = '0;
        coeff_select    = SEL_GAIN;
        coeff_value     = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        hold_requests   = 0;
        burst_left      = 0;
        active_sections = SECTIONS;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed: full cascade at reset order
        for (int i = 0; i < SECTIONS; i++)
            load_stable_section(i);
        filter_sample(SAMPLE_MAX);
        filter_sample(SAMPLE_MIN);
        filter_sample('0);
        filter_sample(1);
        filter_sample(-1);
        filter_sample(SAMPLE_MAX);
        filter_sample(SAMPLE_MAX);
        write_coeff(3, SEL_NONE, 32'h7FFF_FFFF);
        filter_sample(SAMPLE_MAX);
        // saturating section
        write_coeff(0, SEL_GAIN, 32'h7FFF_FFFF);
        write_coeff(0, SEL_A1, 32'h8000_0000);
        write_coeff(0, SEL_A2, 32'h8000_0000);
        filter_sample(SAMPLE_MAX);
        filter_sample(SAMPLE_MIN);
        filter_sample(SAMPLE_MAX);
        load_stable_section(0);
        // pass-through
        set_order('0);
        filter_sample(SAMPLE_MIN);
        filter_sample(SAMPLE_MAX);
        // odd order, one section
        set_order(3);
        filter_sample(SAMPLE_MAX);
        filter_sample(-1);

        run_phase(115, 6'd63, 1'b0);
        run_phase(155, 6'd2, 1'b1);
        run_phase(115, 6'd5, 1'b0);
        run_phase(115, 6'd0, 1'b0);
        run_phase(155, 6'd8, 1'b1);
        run_phase(115, 6'd1, 1'b0);
        run_phase(155, 6'd32, 1'b0);
        run_phase(115, 6'd20, 1'b0);
        run_phase(155, ORDER_W'($urandom_range(2, 32)), 1'b0);
        run_phase(190, 6'd4, 1'b0);

        drain();
        if (mismatches == 0 && samples_due == 0)
            $display("PASS biquad_cascade_lowpass");
        else
            $display("FAIL biquad_cascade_lowpass");
        $finish;
    end

endmodule
